// ===== rtl/core/jlvc_pkg.sv =====
package jlvc_pkg;

  // Sizes
  localparam int unsigned NumJointsDefault = 16;
  localparam int unsigned JointW           = 4;
  localparam int unsigned DataW            = 16;
  localparam int unsigned VelLimW          = 15;
  localparam int unsigned SumW             = 7;
  localparam int unsigned AddW             = 3;
  localparam int unsigned PaddrW           = 3;
  localparam int unsigned PdataW           = 32;

  // Register reset values, Q7.8
  localparam logic [VelLimW-1:0]      VelLimitReset     = 15'd1280;
  localparam logic signed [DataW-1:0] TorqueLimitReset  = 16'sd25600;
  localparam logic signed [DataW-1:0] DefaultAngleLimit = 16'sd804;

  // Weights and thresholds
  localparam logic [AddW-1:0] WeightAngle   = 3'd2;
  localparam logic [AddW-1:0] WeightSpeed   = 3'd1;
  localparam logic [AddW-1:0] WeightTorque  = 3'd2;
  localparam logic [SumW-1:0] SumMax        = 7'd127;
  localparam logic [SumW-1:0] CriticalLevel = 7'd4;

  // Item opcodes
  localparam logic OpSample    = 1'b0;
  localparam logic OpLoadLimit = 1'b1;

  // Register indexes, taken from paddr[2]
  localparam logic RegIdxVelocity = 1'b0;
  localparam logic RegIdxTorque   = 1'b1;

  typedef enum logic [1:0] {
    VerdictNone = 2'd0,
    VerdictWarn = 2'd1,
    VerdictCrit = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [VelLimW-1:0]      velocity_limit;
    logic signed [DataW-1:0] torque_limit;
  } limits_t;

  typedef struct packed {
    logic                    op;
    logic [JointW-1:0]       joint;
    logic signed [DataW-1:0] angle;
    logic signed [DataW-1:0] velocity;
    logic signed [DataW-1:0] torque;
    logic                    torque_present;
    logic signed [DataW-1:0] limit_value;
    logic                    last;
  } sample_t;

endpackage

// ===== rtl/core/jlvc_in_if.sv =====
interface jlvc_in_if;
  import jlvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [JointW-1:0]       joint;
  logic signed [DataW-1:0] angle;
  logic signed [DataW-1:0] velocity;
  logic signed [DataW-1:0] torque;
  logic                    torque_present;
  logic signed [DataW-1:0] limit_value;
  logic                    last;

  modport source (
    output valid, op, joint, angle, velocity, torque, torque_present, limit_value, last,
    input  ready
  );

  modport sink (
    input  valid, op, joint, angle, velocity, torque, torque_present, limit_value, last,
    output ready
  );
endinterface

// ===== rtl/core/jlvc_out_if.sv =====
interface jlvc_out_if;
  import jlvc_pkg::*;

  logic             valid;
  logic             ready;
  logic [SumW-1:0]  violation_sum;
  verdict_e         verdict;

  modport source (
    output valid, violation_sum, verdict,
    input  ready
  );

  modport sink (
    input  valid, violation_sum, verdict,
    output ready
  );
endinterface

// ===== rtl/core/jlvc_cfg_regs.sv =====
module jlvc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jlvc_pkg::PaddrW-1:0]     paddr,
  input  logic [jlvc_pkg::PdataW-1:0]     pwdata,
  output logic [jlvc_pkg::PdataW-1:0]     prdata,
  output logic                            pready,
  output jlvc_pkg::limits_t               limits_o
);
  import jlvc_pkg::*;

  logic [VelLimW-1:0]      vel_lim_q;
  logic signed [DataW-1:0] tq_lim_q;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes, decoded on the word address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_lim_q <= VelLimitReset;
      tq_lim_q  <= TorqueLimitReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegIdxVelocity: vel_lim_q <= pwdata[VelLimW-1:0];
        RegIdxTorque:   tq_lim_q  <= pwdata[DataW-1:0];
        default:        ;
      endcase
    end
  end

  // readback: torque limit sign extended
  always_comb begin
    unique case (paddr[2])
      RegIdxVelocity: prdata = {{(PdataW-VelLimW){1'b0}}, vel_lim_q};
      RegIdxTorque:   prdata = {{(PdataW-DataW){tq_lim_q[DataW-1]}}, tq_lim_q};
      default:        prdata = '0;
    endcase
  end

  assign limits_o.velocity_limit = vel_lim_q;
  assign limits_o.torque_limit   = tq_lim_q;
endmodule

// ===== rtl/core/jlvc_limit_table.sv =====
module jlvc_limit_table #(
  parameter int unsigned NUM_JOINTS = jlvc_pkg::NumJointsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [jlvc_pkg::JointW-1:0]       wr_joint_i,
  input  logic signed [jlvc_pkg::DataW-1:0] wr_limit_i,
  input  logic [jlvc_pkg::JointW-1:0]       rd_joint_i,
  output logic signed [jlvc_pkg::DataW-1:0] rd_limit_o
);
  import jlvc_pkg::*;

  // only 2**JointW entries are reachable by the joint field
  localparam int unsigned Reach = 1 << JointW;
  localparam int unsigned Depth = (NUM_JOINTS < Reach) ? NUM_JOINTS : Reach;

  logic signed [DataW-1:0] tbl_q [Depth];

  // per-entry storage, every entry resets to the default limit
  for (genvar g = 0; g < Depth; g++) begin : g_entry
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tbl_q[g] <= DefaultAngleLimit;
      end else if (wr_en_i && (wr_joint_i == JointW'(g))) begin
        tbl_q[g] <= wr_limit_i;
      end
    end
  end

  // read; a joint past the table sees the default limit
  always_comb begin
    rd_limit_o = DefaultAngleLimit;
    for (int i = 0; i < Depth; i++) begin
      if (rd_joint_i == JointW'(i)) begin
        rd_limit_o = tbl_q[i];
      end
    end
  end
endmodule

// ===== rtl/core/jlvc_eval.sv =====
module jlvc_eval (
  input  logic signed [jlvc_pkg::DataW-1:0] angle_i,
  input  logic signed [jlvc_pkg::DataW-1:0] velocity_i,
  input  logic signed [jlvc_pkg::DataW-1:0] torque_i,
  input  logic                              torque_present_i,
  input  logic signed [jlvc_pkg::DataW-1:0] angle_limit_i,
  input  jlvc_pkg::limits_t                 limits_i,
  output logic [jlvc_pkg::AddW-1:0]         add_o
);
  import jlvc_pkg::*;

  // |v| saturated to 32767
  function automatic logic [DataW-2:0] abs_sat(input logic signed [DataW-1:0] v);
    logic [DataW-1:0] m;
    m = v[DataW-1] ? DataW'(-v) : DataW'(v);
    return m[DataW-1] ? {(DataW-1){1'b1}} : m[DataW-2:0];
  endfunction

  logic [DataW-2:0]        abs_angle;
  logic [DataW-2:0]        abs_vel;
  logic [DataW-2:0]        abs_tq;
  logic signed [DataW-1:0] alim;
  logic                    angle_hit;
  logic                    speed_hit;
  logic                    torque_hit;

  assign abs_angle = abs_sat(angle_i);
  assign abs_vel   = abs_sat(velocity_i);
  assign abs_tq    = abs_sat(torque_i);

  // non-positive stored limit falls back to the default
  assign alim = (angle_limit_i > 0) ? angle_limit_i : DefaultAngleLimit;

  assign angle_hit  = $signed({1'b0, abs_angle}) > alim;
  assign speed_hit  = abs_vel > limits_i.velocity_limit;
  assign torque_hit = torque_present_i && (limits_i.torque_limit > 0) &&
                      ({1'b0, abs_tq} > $unsigned(limits_i.torque_limit));

  assign add_o = (angle_hit  ? WeightAngle  : '0) +
                 (speed_hit  ? WeightSpeed  : '0) +
                 (torque_hit ? WeightTorque : '0);
endmodule

// ===== rtl/core/joint_limit_violation_checker_core.sv =====
// Joint limit violation checker.
// Input channel item_i carries one word per joint: op=0 is a joint sample
// (angle, velocity, torque in signed Q7.8), op=1 loads that joint's angle
// limit from limit_value. Samples of an action add weighted violations to a
// running sum; the sample marked last closes the action and yields one word
// on res_o with the sum and a verdict (none, warning, critical).
// The APB port holds velocity_limit (0x0) and torque_limit (0x4); write them
// only while the block is idle.
// Flow: a word is registered in the input register at acceptance and
// evaluated there; a last sample's result is then loaded into the output
// register, which drives res_o.
// Throughput: one word per cycle while no last sample waits on a held
// res_o, set by the single evaluation stage and the output register.
// Stall: while res_o is held, words without a result keep flowing; a last
// sample waits in the input register and ready stays low until the result
// is taken.
// Reset: limits return to 5.0 and 100.0, the running sum clears and every
// angle limit returns to 3.14 rad.
module joint_limit_violation_checker_core #(
  parameter int unsigned NUM_JOINTS = jlvc_pkg::NumJointsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  jlvc_in_if.sink                     item_i,
  jlvc_out_if.source                  res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jlvc_pkg::PaddrW-1:0] paddr,
  input  logic [jlvc_pkg::PdataW-1:0] pwdata,
  output logic [jlvc_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import jlvc_pkg::*;

  limits_t                 limits;
  sample_t                 smp_q;
  logic                    s1_valid_q;
  logic                    s1_has_res;
  logic                    s1_adv;
  logic                    accept;
  logic signed [DataW-1:0] tbl_limit;
  logic [AddW-1:0]         add;
  logic [SumW:0]           sum_wide;
  logic [SumW-1:0]         sum_sat;
  logic [SumW-1:0]         sum_q;
  logic                    out_valid_q;
  logic [SumW-1:0]         out_sum_q;
  verdict_e                out_verdict_q;
  verdict_e                verdict_d;

  jlvc_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .limits_o (limits)
  );

  // handshake: the stage moves on unless its result would hit a full output
  assign s1_has_res  = s1_valid_q && (smp_q.op == OpSample) && smp_q.last;
  assign s1_adv      = s1_valid_q && (!s1_has_res || !out_valid_q || res_o.ready);
  assign item_i.ready = !s1_valid_q || s1_adv;
  assign accept      = item_i.valid && item_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q.op             <= item_i.op;
      smp_q.joint          <= item_i.joint;
      smp_q.angle          <= item_i.angle;
      smp_q.velocity       <= item_i.velocity;
      smp_q.torque         <= item_i.torque;
      smp_q.torque_present <= item_i.torque_present;
      smp_q.limit_value    <= item_i.limit_value;
      smp_q.last           <= item_i.last;
    end
  end

  jlvc_limit_table #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (s1_adv && (smp_q.op == OpLoadLimit)),
    .wr_joint_i (smp_q.joint),
    .wr_limit_i (smp_q.limit_value),
    .rd_joint_i (smp_q.joint),
    .rd_limit_o (tbl_limit)
  );

  jlvc_eval u_eval (
    .angle_i          (smp_q.angle),
    .velocity_i       (smp_q.velocity),
    .torque_i         (smp_q.torque),
    .torque_present_i (smp_q.torque_present),
    .angle_limit_i    (tbl_limit),
    .limits_i         (limits),
    .add_o            (add)
  );

  // saturating accumulate
  assign sum_wide = {1'b0, sum_q} + {{(SumW+1-AddW){1'b0}}, add};
  assign sum_sat  = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];

  always_comb begin
    priority if (sum_sat == '0) begin
      verdict_d = VerdictNone;
    end else if (sum_sat >= CriticalLevel) begin
      verdict_d = VerdictCrit;
    end else begin
      verdict_d = VerdictWarn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_adv && (smp_q.op == OpSample)) begin
      sum_q <= smp_q.last ? '0 : sum_sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_has_res) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_has_res) begin
      out_sum_q     <= sum_sat;
      out_verdict_q <= verdict_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.violation_sum = out_sum_q;
  assign res_o.verdict       = out_verdict_q;
endmodule

// ===== sim/joint_limit_violation_checker_core_tb.sv =====
module joint_limit_violation_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jlvc_pkg::*;

  localparam int JOINT_CNT = 16;

  typedef struct {
    logic [SumW-1:0] total;
    verdict_e        grade;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  // APB side
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  jlvc_in_if  item_if ();
  jlvc_out_if res_if ();

  joint_limit_violation_checker_core #(
    .NUM_JOINTS (JOINT_CNT)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: limits, running total and angle limit table
  logic [VelLimW-1:0]      vel_lim;
  logic signed [DataW-1:0] trq_lim;
  int                      running_total;
  logic signed [DataW-1:0] limit_tab [JOINT_CNT];
  // Table as the stimulus generator expects it to be once its words land
  logic signed [DataW-1:0] gen_tab [JOINT_CNT];

  sample_t joint_words [$];
  report_t pending_reports [$];

  int send_gap_max;
  int take_gap_max;
  int send_wait;
  int take_wait;
  int words_queued;
  int words_accepted;
  int loads_accepted;
  int settings_used;
  int error_count;
  int verdict_seen [3];

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Saturating magnitude of a Q7.8 word
  function automatic int magnitude(input logic signed [DataW-1:0] v);
    int a;
    a = int'(v);
    if (a < 0) a = -a;
    if (a > 32767) a = 32767;
    return a;
  endfunction

  // Work out what one accepted word does to the running total
  task automatic score_word(input sample_t w);
    int lim;
    int add;
    if (w.op == OpLoadLimit) begin
      loads_accepted++;
      if (w.joint < JOINT_CNT) limit_tab[w.joint] = w.limit_value;
    end else begin
      lim = int'(DefaultAngleLimit);
      if (w.joint < JOINT_CNT && limit_tab[w.joint] > 0) lim = int'(limit_tab[w.joint]);
      add = 0;
      if (magnitude(w.angle) > lim) add += int'(WeightAngle);
      if (magnitude(w.velocity) > int'(vel_lim)) add += int'(WeightSpeed);
      if (w.torque_present && trq_lim > 0 && magnitude(w.torque) > int'(trq_lim))
        add += int'(WeightTorque);
      running_total += add;
      if (running_total > int'(SumMax)) running_total = int'(SumMax);
      if (w.last) begin
        report_t r;
        r.total = running_total[SumW-1:0];
        if (running_total == 0) r.grade = VerdictNone;
        else if (running_total >= int'(CriticalLevel)) r.grade = VerdictCrit;
        else r.grade = VerdictWarn;
        pending_reports.push_back(r);
        running_total = 0;
      end
    end
  endtask

  // Word driver: one word per handshake, random gap after each word
  always @(posedge clk_i or negedge rst_ni) begin : word_driver
    sample_t nxt;
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      send_wait <= 0;
    end else if (!item_if.valid || item_if.ready) begin
      if (send_wait != 0) begin
        item_if.valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (joint_words.size() != 0) begin
        nxt = joint_words.pop_front();
        item_if.op             <= nxt.op;
        item_if.joint          <= nxt.joint;
        item_if.angle          <= nxt.angle;
        item_if.velocity       <= nxt.velocity;
        item_if.torque         <= nxt.torque;
        item_if.torque_present <= nxt.torque_present;
        item_if.limit_value    <= nxt.limit_value;
        item_if.last           <= nxt.last;
        item_if.valid          <= 1'b1;
        send_wait <= $urandom_range(0, send_gap_max);
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stall after each word taken
  always @(posedge clk_i or negedge rst_ni) begin : report_sink
    int n;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      take_wait <= 0;
    end else if (res_if.valid && res_if.ready) begin
      n = $urandom_range(0, take_gap_max);
      take_wait <= n;
      res_if.ready <= (n == 0);
    end else if (take_wait != 0) begin
      take_wait <= take_wait - 1;
      res_if.ready <= (take_wait == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Monitor: predict on accepted words, check accepted results
  always @(posedge clk_i) begin : monitor
    sample_t seen;
    report_t want;
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) begin
        seen.op             = item_if.op;
        seen.joint          = item_if.joint;
        seen.angle          = item_if.angle;
        seen.velocity       = item_if.velocity;
        seen.torque         = item_if.torque;
        seen.torque_present = item_if.torque_present;
        seen.limit_value    = item_if.limit_value;
        seen.last           = item_if.last;
        words_accepted++;
        score_word(seen);
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected result sum=%0d verdict=%0d",
                                    res_if.violation_sum, res_if.verdict));
        end else begin
          want = pending_reports.pop_front();
          if (res_if.violation_sum !== want.total)
            report_mismatch($sformatf("violation_sum %0d, expected %0d",
                                      res_if.violation_sum, want.total));
          if (res_if.verdict !== want.grade)
            report_mismatch($sformatf("verdict %0d, expected %s",
                                      res_if.verdict, want.grade.name()));
          verdict_seen[want.grade]++;
        end
      end
    end
  end

  task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [PdataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [PaddrW-1:0] addr, output logic [PdataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read both limits back and compare with the predictor's copy
  task automatic check_limits();
    logic [PdataW-1:0] got;
    apb_read({RegIdxVelocity, 2'b00}, got);
    if (got[VelLimW-1:0] !== vel_lim)
      report_mismatch($sformatf("velocity_limit reads %0d, expected %0d",
                                got[VelLimW-1:0], vel_lim));
    apb_read({RegIdxTorque, 2'b00}, got);
    if (got[DataW-1:0] !== trq_lim)
      report_mismatch($sformatf("torque_limit reads %0d, expected %0d",
                                $signed(got[DataW-1:0]), trq_lim));
  endtask

  task automatic set_limits(input logic [VelLimW-1:0] v, input logic signed [DataW-1:0] t);
    apb_write({RegIdxVelocity, 2'b00}, {{(PdataW-VelLimW){1'b0}}, v});
    apb_write({RegIdxTorque, 2'b00}, {{(PdataW-DataW){t[DataW-1]}}, t});
    vel_lim = v;
    trq_lim = t;
    settings_used++;
    check_limits();
  endtask

  // Wait until every queued word is in and every result is out, then let the pipeline empty
  task automatic drain_pipeline();
    while (words_accepted != words_queued || pending_reports.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_word(input sample_t w);
    if (w.op == OpLoadLimit && w.joint < JOINT_CNT) gen_tab[w.joint] = w.limit_value;
    joint_words.push_back(w);
    words_queued++;
  endtask

  function automatic sample_t sample_word(input logic [JointW-1:0] j, input int a, input int v,
                                          input int t, input bit tp, input bit closing);
    sample_t s;
    s.op             = OpSample;
    s.joint          = j;
    s.angle          = DataW'(a);
    s.velocity       = DataW'(v);
    s.torque         = DataW'(t);
    s.torque_present = tp;
    s.limit_value    = DataW'($urandom);
    s.last           = closing;
    return s;
  endfunction

  function automatic sample_t load_word(input logic [JointW-1:0] j, input int lim,
                                        input bit closing);
    sample_t s;
    s.op             = OpLoadLimit;
    s.joint          = j;
    s.angle          = DataW'($urandom);
    s.velocity       = DataW'($urandom);
    s.torque         = DataW'($urandom);
    s.torque_present = 1'($urandom_range(0, 1));
    s.limit_value    = DataW'(lim);
    s.last           = closing;
    return s;
  endfunction

  // Value close to +/- a threshold, sometimes anywhere, at the rails or near zero
  function automatic logic signed [DataW-1:0] near(input int thr);
    int v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: begin
        v = thr + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      5: v = int'($urandom_range(0, 65535)) - 32768;
      6: v = $urandom_range(0, 1) ? -32768 : 32767;
      default: v = int'($urandom_range(0, 64)) - 32;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[DataW-1:0];
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return -int'($urandom_range(1, 32768));
      2: return 32767;
      3: return int'(DefaultAngleLimit);
      default: return $urandom_range(1, 2000);
    endcase
  endfunction

  function automatic sample_t random_sample(input logic [JointW-1:0] j, input bit closing,
                                            input bit hot);
    sample_t s;
    int eff;
    eff = int'(DefaultAngleLimit);
    if (j < JOINT_CNT && gen_tab[j] > 0) eff = int'(gen_tab[j]);
    s = sample_word(j, 0, 0, 0, 1'($urandom_range(0, 1)), closing);
    if (hot) begin
      // rail values trip nearly every check
      s.angle          = DataW'($urandom_range(0, 1) ? -32768 : 32767);
      s.velocity       = DataW'($urandom_range(0, 1) ? -32768 : 32767);
      s.torque         = DataW'($urandom_range(0, 1) ? -32768 : 32767);
      s.torque_present = 1'b1;
    end else begin
      s.angle    = near(eff);
      s.velocity = near(int'(vel_lim));
      s.torque   = near((trq_lim > 0) ? int'(trq_lim) : int'($urandom_range(1, 32767)));
    end
    return s;
  endfunction

  // One action: a run of samples closed by last, limit loads mixed in
  task automatic queue_action();
    int  len;
    bit  hot;
    hot = ($urandom_range(0, 9) == 0);
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(26, 34) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_word(load_word(JointW'($urandom_range(0, 15)), pick_limit(),
                            1'($urandom_range(0, 1))));
      push_word(random_sample(JointW'($urandom_range(0, 15)), i == len - 1, hot));
    end
  endtask

  task automatic run_phase(input logic [VelLimW-1:0] v, input logic signed [DataW-1:0] t,
                           input int sgap, input int tgap, input int count);
    int target;
    drain_pipeline();
    set_limits(v, t);
    send_gap_max = sgap;
    take_gap_max = tgap;
    target = words_queued + count;
    while (words_queued < target) queue_action();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_if.valid = 1'b0;
    item_if.op = OpSample;
    item_if.joint = '0;
    item_if.angle = '0;
    item_if.velocity = '0;
    item_if.torque = '0;
    item_if.torque_present = 1'b0;
    item_if.limit_value = '0;
    item_if.last = 1'b0;
    res_if.ready = 1'b0;
    vel_lim = VelLimitReset;
    trq_lim = TorqueLimitReset;
    running_total = 0;
    for (int i = 0; i < JOINT_CNT; i++) begin
      limit_tab[i] = DefaultAngleLimit;
      gen_tab[i] = DefaultAngleLimit;
    end
    send_gap_max = 3;
    take_gap_max = 3;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_limits();

    // Directed words at reset limits
    push_word(sample_word(0, 804, 1280, 25600, 1, 1));      // exactly on every limit
    push_word(sample_word(1, 805, -1281, -25601, 1, 1));    // all three trip
    push_word(sample_word(2, -32768, -32768, -32768, 0, 1)); // rails, torque absent
    push_word(sample_word(3, 32767, 32767, 32767, 1, 0));
    push_word(sample_word(15, -805, 0, 0, 0, 1));            // two-sample action
    push_word(load_word(4, 0, 0));                           // zero limit falls back
    push_word(sample_word(4, 805, 0, 0, 0, 1));
    push_word(sample_word(4, 804, 1280, 0, 1, 1));
    push_word(load_word(5, -32768, 0));                      // negative limit falls back
    push_word(sample_word(5, 900, 0, 0, 0, 1));
    push_word(load_word(6, 100, 1));                         // load with last: no result
    push_word(sample_word(6, 101, 0, 0, 0, 0));
    push_word(load_word(7, 32767, 1));
    push_word(sample_word(7, -32768, 1281, 0, 0, 1));
    push_word(load_word(8, 1, 0));
    push_word(sample_word(8, 2, 0, 0, 1, 0));
    push_word(sample_word(8, -1, -1, 0, 1, 1));
    push_word(sample_word(9, 0, 0, 0, 0, 1));                // clean action

    // Random actions under several limit settings
    run_phase(15'd0, 16'sd1, 10, 10, 120);
    run_phase(15'd32767, 16'sd32767, 0, 0, 120);
    run_phase(VelLimW'($urandom_range(1, 3000)), 16'sd0, 10, 0, 120);
    run_phase(VelLimW'($urandom_range(1, 3000)), 16'sh8000, 0, 10, 120);
    run_phase(VelLimitReset, DataW'($urandom_range(1, 32767)), 10, 10, 120);

    drain_pipeline();
    repeat (6) @(posedge clk_i);
    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_reports.size()));

    $display("Ran %0d words (%0d limit loads) under %0d limit settings.",
             words_accepted, loads_accepted, settings_used + 1);
    $display("Results checked: %0d clean, %0d warning, %0d critical; %0d mismatches.",
             verdict_seen[VerdictNone], verdict_seen[VerdictWarn],
             verdict_seen[VerdictCrit], error_count);
    if (error_count == 0) begin
      $display("joint_limit_violation_checker_core regression: pass");
    end else begin
      $display("joint_limit_violation_checker_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding.", pending_reports.size());
    $display("joint_limit_violation_checker_core regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/jlvc_pkg.sv
rtl/core/jlvc_in_if.sv
rtl/core/jlvc_out_if.sv
rtl/core/jlvc_cfg_regs.sv
rtl/core/jlvc_limit_table.sv
rtl/core/jlvc_eval.sv
rtl/core/joint_limit_violation_checker_core.sv
sim/joint_limit_violation_checker_core_tb.sv
